@@ sv/clxp_pkg.sv @@
// Package: widths, constants and register indexes of the counter LCG xorshift generator.
`timescale 1ns / 1ps

package clxp_pkg;

    // Modulus is 2**MOD_W; reduction modulo MODULUS keeps the low MOD_W bits.
    localparam int unsigned MOD_W   = 32;
    localparam logic [64:0] MODULUS = 65'd1 << MOD_W;

    localparam int unsigned CFG_W   = 64;
    localparam int unsigned OUT_W   = 32;
    localparam int unsigned WORD_W  = 64;

    localparam int unsigned STEP_SCALE = 23;
    localparam int unsigned SHIFT_A    = 21;
    localparam int unsigned SHIFT_B    = 35;
    localparam int unsigned SHIFT_C    = 4;

    localparam logic [64:0] STEP_LIMIT = MODULUS / STEP_SCALE;
    localparam int unsigned CNT_W      = $clog2(STEP_LIMIT);

    typedef enum logic [1:0] {
        REG_SEED      = 2'd0,
        REG_MULTIPLIER = 2'd1,
        REG_INCREMENT = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

endpackage

@@ sv/counter_lcg_xorshift_prng.sv @@
// Top level: counter-based LCG plus xorshift random generator, three-stage pipeline.
`timescale 1ns / 1ps
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------
//  in       | in_valid / in_ready | draw (1 bit)
//  out      | out_valid/out_ready | random_value (32 bit)
//  cfg      | cfg_we              | cfg_index (2), cfg_data (64)
//
//  One word per cycle while the output is not stalled; out_valid follows the accepted word through v1, v2 and v3.
//  Stages: counter step and scale, 32x32 multiply-add, xorshift into output register.
//  A stalled output freezes all stages; in_ready = !out_valid || out_ready.
//  A word with draw low is accepted and yields no result.
//  Reset clears the step counter, the stage valids, seed and increment, and sets the multiplier to one.

module counter_lcg_xorshift_prng
    import clxp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                draw,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    random_value,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [MOD_W-1:0] seed_reg;
    logic [MOD_W-1:0] mult_reg;
    logic [MOD_W-1:0] incr_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [MOD_W-1:0] scale_reg, scale_next;

    logic             v1_reg, v2_reg, v3_reg;
    logic [MOD_W-1:0] s1_reg;
    logic [MOD_W-1:0] x2_reg, x2_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic             advance;
    logic             take;
    logic [WORD_W-1:0] w_a, w_b, w_c;

    assign advance   = !v3_reg || out_ready;
    assign in_ready  = advance;
    assign take      = in_valid && advance && draw;
    assign out_valid = v3_reg;
    assign random_value = out_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            mult_reg <= MOD_W'(1);
            incr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SEED:       seed_reg <= cfg_data[MOD_W-1:0];
                REG_MULTIPLIER: mult_reg <= cfg_data[MOD_W-1:0];
                REG_INCREMENT:  incr_reg <= cfg_data[MOD_W-1:0];
                REG_NONE:       ;
            endcase
        end
    end

    // step counter and its multiple of STEP_SCALE
    always_comb
    begin
        if ({1'b0, count_reg} + (CNT_W+1)'(1) == (CNT_W+1)'(STEP_LIMIT))
        begin
            count_next = '0;
            scale_next = '0;
        end
        else
        begin
            count_next = count_reg + CNT_W'(1);
            scale_next = scale_reg + MOD_W'(STEP_SCALE);
        end
    end

    always_comb
    begin
        x2_next = seed_reg + mult_reg * s1_reg + incr_reg;
    end

    always_comb
    begin
        w_a = {{(WORD_W-MOD_W){1'b0}}, x2_reg};
        w_a = w_a ^ (w_a >> SHIFT_A);
        w_b = w_a ^ (w_a << SHIFT_B);
        w_c = w_b ^ (w_b >> SHIFT_C);
        out_next = w_c[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scale_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (take)
            begin
                count_reg <= count_next;
                scale_reg <= scale_next;
            end
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= scale_next;
            x2_reg  <= x2_next;
            out_reg <= out_next;
        end
    end

endmodule

@@ sv/clxp_checker.sv @@
// Checker: port-level assertions for the generator, bound to the top level.
`timescale 1ns / 1ps

module clxp_checker
    import clxp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] random_value
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_value))
        else $error("stalled output word changed");

    // input side is back-pressured only by a stalled output register
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    a_stall_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> out_valid)
        else $error("input stalled without a pending output word");

endmodule

bind counter_lcg_xorshift_prng clxp_checker u_clxp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
);

@@ bench/counter_lcg_xorshift_prng_tb.sv @@
// Testbench: counter LCG xorshift generator, every output word checked against an inline predictor.
`timescale 1ns / 1ps

module counter_lcg_xorshift_prng_tb;
    import clxp_pkg::*;

    localparam int unsigned TAIL_CYCLES = 6;
    localparam int unsigned MAX_SHOWN   = 40;
    localparam int unsigned PHASE_DRAWS = 280;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             draw      = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] random_value;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = REG_NONE;
    logic [CFG_W-1:0] cfg_data  = '0;

    logic [CFG_W-1:0] seed_copy = '0, mult_copy = 64'd1, incr_copy = '0;
    logic [CNT_W-1:0] step_count = '0;
    logic             draw_queue[$];
    logic [OUT_W-1:0] expected_values[$];
    bit               calm = 1'b0;
    int unsigned      mismatches = 0;
    int unsigned      send_gap = 0;
    int unsigned      recv_gap = 0;

    counter_lcg_xorshift_prng u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .draw         (draw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [OUT_W-1:0] lcg_xorshift(input logic [CNT_W-1:0] count);
        logic [WORD_W-1:0] x;
        x = seed_copy + mult_copy * (WORD_W'(count) * WORD_W'(STEP_SCALE)) + incr_copy;
        x = WORD_W'({1'b0, x} % MODULUS);
        x = x ^ (x >> SHIFT_A);
        x = x ^ (x << SHIFT_B);
        x = x ^ (x >> SHIFT_C);
        x = WORD_W'({1'b0, x} % MODULUS);
        return x[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            $display("%0t ns: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic load_register(input reg_index_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SEED:       seed_copy = value;
            REG_MULTIPLIER: mult_copy = value;
            REG_INCREMENT:  incr_copy = value;
            default:        ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // returns once every queued word is sent and every expected word has come back
    task automatic drain();
        do
            @(negedge clk);
        while (draw_queue.size() != 0 || in_valid || expected_values.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : word_driver
        logic [64:0] bumped;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            draw     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready && draw)
            begin
                bumped     = 65'(step_count) + 65'd1;
                step_count = CNT_W'(bumped % STEP_LIMIT);
                expected_values = {expected_values, lcg_xorshift(step_count)};
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (draw_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    draw     <= draw_queue.pop_front();
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : word_monitor
        logic [OUT_W-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    report_mismatch($sformatf("word %h with none expected", random_value));
                end
                else
                begin
                    want = expected_values.pop_front();
                    if (random_value !== want)
                    begin
                        report_mismatch($sformatf("random_value %h, want %h",
                                                  random_value, want));
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned ones;
        logic        bit_draw;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, first draw uses count one; idle words in between
        load_register(REG_NONE, {$urandom, $urandom});
        draw_queue = {1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
        drain();

        // full wrap of the product and the sums
        load_register(REG_SEED, '1);
        load_register(REG_MULTIPLIER, '1);
        load_register(REG_INCREMENT, '1);
        draw_queue = {1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        drain();

        load_register(REG_SEED, '0);
        load_register(REG_MULTIPLIER, '0);
        load_register(REG_INCREMENT, '0);
        draw_queue = {1'b1, 1'b0, 1'b1, 1'b1};
        drain();

        load_register(REG_SEED, 64'h8000_0000_0000_0000);
        load_register(REG_MULTIPLIER, 64'h0000_0001_0000_0001);
        load_register(REG_INCREMENT, 64'h0000_0000_FFFF_FFFF);
        draw_queue = {1'b1, 1'b1, 1'b1, 1'b1};
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:
                begin
                    load_register(REG_SEED, {$urandom, $urandom});
                    load_register(REG_MULTIPLIER, '1);
                    load_register(REG_INCREMENT, '0);
                end
                2:
                begin
                    load_register(REG_SEED, '0);
                    load_register(REG_MULTIPLIER, {32'd0, $urandom});
                    load_register(REG_INCREMENT, '1);
                    load_register(REG_NONE, {$urandom, $urandom});
                end
                default:
                begin
                    load_register(REG_SEED, {$urandom, $urandom});
                    load_register(REG_MULTIPLIER, {$urandom, $urandom});
                    load_register(REG_INCREMENT, {$urandom, $urandom});
                end
            endcase
            calm = (phase == 4);
            ones = 0;
            while (ones < PHASE_DRAWS)
            begin
                bit_draw = ($urandom_range(0, 6) != 0);
                draw_queue = {draw_queue, bit_draw};
                if (bit_draw)
                begin
                    ones++;
                end
            end
            drain();
        end

        if (mismatches == 0)
        begin
            $display("counter_lcg_xorshift_prng_tb: PASS");
        end
        else
        begin
            $display("counter_lcg_xorshift_prng_tb: FAIL");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("counter_lcg_xorshift_prng_tb: FAIL");
        $finish;
    end

endmodule
